/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL; clk and rst must exist in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/mrr_pkg.sv */
// Shared codes and constants of the multilevel round-robin scheduler.
package mrr_pkg;

  typedef enum logic [1:0] {
    SLOT_FREE  = 2'd0,
    SLOT_ALLOC = 2'd1,
    SLOT_RUN   = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    FN_ALLOC  = 2'd0,
    FN_RUN    = 2'd1,
    FN_SLEEP  = 2'd2,
    FN_SWITCH = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_IGN  = 2'd2
  } status_t;

  localparam logic [7:0] SLICE_START = 8'd2;

endpackage

/* hdl/multilevel_round_robin_scheduler.sv */
// Multilevel round-robin scheduler: sequencer, level counters and the two memories.
// One operation is taken at a time and the block holds in_ready low until it has
// finished. After reset a clearing pass over all NUM_SLOTS entries initializes the slot
// memory before the first operation is taken. Alloc scans the slot memory one slot
// at a time, reading then checking each; a sleep or a level-changing run searches
// and then compacts the level list in the list memory, reading then writing each
// entry it shifts. The result sits in an output register until taken; a new
// operation can be accepted meanwhile.
module multilevel_round_robin_scheduler #(
  parameter int NUM_SLOTS       = 64,
  parameter int NUM_LEVELS      = 8,
  parameter int SLOTS_PER_LEVEL = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [5:0]        task_id,
  input  logic signed [3:0] new_level,
  input  logic [7:0]        new_priority,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [5:0]        chosen_task,
  output logic [7:0]        slice_ticks,
  output logic              do_jump,
  output logic [5:0]        running_task
);

`include "assert_macros.svh"

  localparam int SW  = $clog2(NUM_SLOTS);
  localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CW  = $clog2(SLOTS_PER_LEVEL + 1);
  localparam int KW  = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
  localparam int LD  = NUM_LEVELS * SLOTS_PER_LEVEL;
  localparam int LAW = (LD > 1) ? $clog2(LD) : 1;

  typedef struct packed {
    mrr_pkg::slot_st_t st;
    logic [LW-1:0]     lvl;
    logic [7:0]        prio;
  } rec_t;

  typedef enum logic [23:0] {
    S_CLR      = 24'h000001,
    S_IDLE     = 24'h000002,
    S_AL_RD    = 24'h000004,
    S_AL_CK    = 24'h000008,
    S_SL_RD    = 24'h000010,
    S_SL_CK    = 24'h000020,
    S_RUN_APP  = 24'h000040,
    S_SLP_REM  = 24'h000080,
    S_SLP_POST = 24'h000100,
    S_SLP_CUR  = 24'h000200,
    S_SLP_SEL  = 24'h000400,
    S_SW_ADV   = 24'h000800,
    S_SW_CUR   = 24'h001000,
    S_SW_SEL   = 24'h002000,
    S_SW_PR    = 24'h004000,
    S_CUR      = 24'h008000,
    S_CURW     = 24'h010000,
    S_PICK     = 24'h020000,
    S_RM_RD    = 24'h040000,
    S_RM_CK    = 24'h080000,
    S_SH_RD    = 24'h100000,
    S_SH_WR    = 24'h200000,
    S_RM_END   = 24'h400000,
    S_FIN      = 24'h800000
  } state_t;

  // Completion is tracked by the done_pend flag rather than by a state of its own.
  state_t state, ret;
  logic   done_pend;

  logic [1:0]        f_func;
  logic [5:0]        f_task;
  logic signed [3:0] f_lvl;
  logic [7:0]        f_prio;

  rec_t          rec;
  logic [SW-1:0] idx;
  logic [LW-1:0] pidx;
  logic [LW-1:0] act;
  logic          act_none;
  logic          recheck;
  logic [SW-1:0] prev_cur, cur;
  logic          had, cur_ok;
  logic [LW-1:0] rem_lv, tgt;
  logic [CW-1:0] rem_i, rem_c;
  logic [1:0]    r_status;
  logic [SW-1:0] r_chosen;
  logic [7:0]    r_slice;
  logic          r_jump;

  logic [CW-1:0] cnt [NUM_LEVELS];
  logic [KW-1:0] crs [NUM_LEVELS];

  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  rec_t          s_wdata, s_rd;
  logic           l_we;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [SW-1:0]  l_wdata, l_rd;

  logic [LW-1:0] ci;
  logic [CW-1:0] cnt_ci;
  logic [KW-1:0] crs_ci;
  logic [CW-1:0] kc;
  logic [CW:0]   kn;
  logic [4:0]    tgt5;

  function automatic logic [LAW-1:0] laddr(input logic [LW-1:0] lv, input logic [CW-1:0] k);
    laddr = LAW'(32'(lv) * SLOTS_PER_LEVEL + 32'(k));
  endfunction

  mrr_ram #(.WIDTH($bits(rec_t)), .DEPTH(NUM_SLOTS)) u_slot_mem (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rd)
  );

  mrr_ram #(.WIDTH(SW), .DEPTH(LD)) u_list_mem (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rd)
  );

  assign in_ready = (state == S_IDLE) && !done_pend;

  // Level counter/cursor index: one address per state.
  always_comb begin
    case (state)
      S_CUR, S_SW_ADV: ci = act;
      S_PICK:          ci = pidx;
      S_RUN_APP:       ci = tgt;
      default:         ci = rem_lv;
    endcase
  end

  assign cnt_ci = cnt[ci];
  assign crs_ci = crs[ci];
  assign kc     = (CW'(crs_ci) >= cnt_ci) ? '0 : CW'(crs_ci);
  assign kn     = (CW+1)'(crs_ci) + (CW+1)'(1);
  assign tgt5   = f_lvl[3] ? 5'(s_rd.lvl) : {1'b0, f_lvl};

  always_comb begin
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = rec;
    s_raddr = '0;
    l_we    = 1'b0;
    l_waddr = '0;
    l_wdata = '0;
    l_raddr = '0;
    case (state)
      S_CLR: begin
        s_we    = 1'b1;
        s_waddr = idx;
        if (idx == '0) begin
          s_wdata = '{st: mrr_pkg::SLOT_RUN, lvl: '0, prio: mrr_pkg::SLICE_START};
          l_we    = 1'b1;
        end else begin
          s_wdata = '{st: mrr_pkg::SLOT_FREE, lvl: '0, prio: '0};
        end
      end
      S_AL_RD: s_raddr = idx;
      S_AL_CK: begin
        if (s_rd.st == mrr_pkg::SLOT_FREE) begin
          s_we    = 1'b1;
          s_waddr = idx;
          s_wdata = s_rd;
          s_wdata.st = mrr_pkg::SLOT_ALLOC;
        end
      end
      S_SL_RD: s_raddr = SW'(f_task);
      S_RUN_APP: begin
        s_we    = 1'b1;
        s_waddr = SW'(f_task);
        if (rec.st != mrr_pkg::SLOT_RUN) begin
          s_wdata.lvl = tgt;
          if (cnt_ci < CW'(SLOTS_PER_LEVEL)) begin
            s_wdata.st = mrr_pkg::SLOT_RUN;
            l_we       = 1'b1;
            l_waddr    = laddr(tgt, cnt_ci);
            l_wdata    = SW'(f_task);
          end
        end
      end
      S_SLP_POST: begin
        s_we    = 1'b1;
        s_waddr = SW'(f_task);
      end
      S_SW_SEL: s_raddr = cur;
      S_CUR:    l_raddr = laddr(act, kc);
      S_RM_RD:  l_raddr = laddr(rem_lv, rem_i);
      S_SH_RD:  l_raddr = laddr(rem_lv, rem_i + CW'(1));
      S_SH_WR: begin
        l_we    = 1'b1;
        l_waddr = laddr(rem_lv, rem_i);
        l_wdata = l_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      ret       <= S_IDLE;
      done_pend <= 1'b0;
      idx       <= '0;
      pidx      <= '0;
      act       <= '0;
      act_none  <= 1'b0;
      recheck   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt[i] <= (i == 0) ? CW'(1) : '0;
        crs[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // Deliver a finished result once the current task is settled and the output is free.
      if (done_pend && state == S_IDLE && (!out_valid || out_ready)) begin
        out_valid    <= 1'b1;
        status       <= r_status;
        chosen_task  <= 6'(r_chosen);
        slice_ticks  <= r_slice;
        do_jump      <= r_jump;
        running_task <= cur_ok ? 6'(cur) : 6'd0;
        done_pend    <= 1'b0;
      end
      case (state)
        S_CLR: begin
          idx <= idx + SW'(1);
          if (idx == SW'(NUM_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            f_func   <= func;
            f_task   <= task_id;
            f_lvl    <= new_level;
            f_prio   <= new_priority;
            r_status <= mrr_pkg::STAT_DONE;
            r_chosen <= '0;
            r_slice  <= '0;
            r_jump   <= 1'b0;
            case (mrr_pkg::func_t'(func))
              mrr_pkg::FN_ALLOC: begin
                idx   <= '0;
                state <= S_AL_RD;
              end
              mrr_pkg::FN_RUN, mrr_pkg::FN_SLEEP: begin
                if (32'(task_id) >= NUM_SLOTS) begin
                  r_status <= mrr_pkg::STAT_IGN;
                  state    <= S_FIN;
                end else begin
                  state <= S_SL_RD;
                end
              end
              default: begin
                ret   <= S_SW_ADV;
                state <= S_CUR;
              end
            endcase
          end
        end
        S_AL_RD: state <= S_AL_CK;
        S_AL_CK: begin
          if (s_rd.st == mrr_pkg::SLOT_FREE) begin
            r_chosen <= idx;
            state    <= S_FIN;
          end else if (idx == SW'(NUM_SLOTS - 1)) begin
            r_status <= mrr_pkg::STAT_FULL;
            state    <= S_FIN;
          end else begin
            idx   <= idx + SW'(1);
            state <= S_AL_RD;
          end
        end
        S_SL_RD: state <= S_SL_CK;
        S_SL_CK: begin
          rec <= '{st: s_rd.st, lvl: s_rd.lvl,
                   prio: (f_func == mrr_pkg::FN_RUN && f_prio != 8'd0) ? f_prio : s_rd.prio};
          if (f_func == mrr_pkg::FN_RUN) begin
            if (32'(tgt5) >= NUM_LEVELS) begin
              r_status <= mrr_pkg::STAT_IGN;
              state    <= S_FIN;
            end else begin
              tgt     <= LW'(tgt5);
              recheck <= 1'b1;
              if (s_rd.st == mrr_pkg::SLOT_RUN && 5'(s_rd.lvl) != tgt5) begin
                rem_lv <= s_rd.lvl;
                rem_i  <= '0;
                ret    <= S_RUN_APP;
                state  <= S_RM_RD;
              end else begin
                state <= S_RUN_APP;
              end
            end
          end else if (s_rd.st != mrr_pkg::SLOT_RUN) begin
            r_status <= mrr_pkg::STAT_IGN;
            state    <= S_FIN;
          end else begin
            ret   <= S_SLP_REM;
            state <= S_CUR;
          end
        end
        S_RUN_APP: begin
          if (rec.st != mrr_pkg::SLOT_RUN) begin
            if (cnt_ci < CW'(SLOTS_PER_LEVEL)) begin
              cnt[tgt] <= cnt_ci + CW'(1);
            end else begin
              r_status <= mrr_pkg::STAT_FULL;
            end
          end
          state <= S_FIN;
        end
        S_SLP_REM: begin
          prev_cur <= cur;
          had      <= cur_ok;
          rem_lv   <= rec.lvl;
          rem_i    <= '0;
          ret      <= S_SLP_POST;
          state    <= S_RM_RD;
        end
        S_SLP_POST: begin
          if (had && prev_cur == SW'(f_task)) begin
            pidx  <= '0;
            ret   <= S_SLP_CUR;
            state <= S_PICK;
          end else begin
            state <= S_FIN;
          end
        end
        S_SLP_CUR: begin
          ret   <= S_SLP_SEL;
          state <= S_CUR;
        end
        S_SLP_SEL: begin
          if (cur_ok) begin
            r_chosen <= cur;
            r_jump   <= 1'b1;
          end
          state <= S_FIN;
        end
        S_SW_ADV: begin
          prev_cur <= cur;
          had      <= cur_ok;
          if (!act_none) begin
            crs[act] <= (kn >= (CW+1)'(cnt_ci)) ? '0 : KW'(kn);
          end
          if (recheck) begin
            pidx  <= '0;
            ret   <= S_SW_CUR;
            state <= S_PICK;
          end else begin
            state <= S_SW_CUR;
          end
        end
        S_SW_CUR: begin
          ret   <= S_SW_SEL;
          state <= S_CUR;
        end
        S_SW_SEL: begin
          if (cur_ok) begin
            r_chosen <= cur;
            r_jump   <= !had || (cur != prev_cur);
            state    <= S_SW_PR;
          end else begin
            r_status <= mrr_pkg::STAT_IGN;
            state    <= S_FIN;
          end
        end
        S_SW_PR: begin
          r_slice <= s_rd.prio;
          state   <= S_FIN;
        end
        S_CUR: begin
          if (act_none || cnt_ci == '0) begin
            cur_ok <= 1'b0;
            state  <= ret;
          end else begin
            state <= S_CURW;
          end
        end
        S_CURW: begin
          cur    <= l_rd;
          cur_ok <= 1'b1;
          state  <= ret;
        end
        S_PICK: begin
          if (cnt_ci != '0) begin
            act      <= pidx;
            act_none <= 1'b0;
            recheck  <= 1'b0;
            state    <= ret;
          end else if (pidx == LW'(NUM_LEVELS - 1)) begin
            act      <= '0;
            act_none <= 1'b1;
            recheck  <= 1'b0;
            state    <= ret;
          end else begin
            pidx <= pidx + LW'(1);
          end
        end
        S_RM_RD: begin
          if (rem_i == cnt_ci) begin
            state <= S_RM_END;
          end else begin
            state <= S_RM_CK;
          end
        end
        S_RM_CK: begin
          if (l_rd == SW'(f_task)) begin
            cnt[rem_lv] <= cnt_ci - CW'(1);
            rem_c       <= cnt_ci - CW'(1);
            if (rem_i < CW'(crs_ci)) begin
              crs[rem_lv] <= crs_ci - KW'(1);
            end
            state <= S_SH_RD;
          end else begin
            rem_i <= rem_i + CW'(1);
            state <= S_RM_RD;
          end
        end
        S_SH_RD: begin
          if (rem_i >= rem_c) begin
            // Wrap the cursor when it now falls past the end.
            if (CW'(crs_ci) >= rem_c) begin
              crs[rem_lv] <= '0;
            end
            state <= S_RM_END;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          rem_i <= rem_i + CW'(1);
          state <= S_SH_RD;
        end
        S_RM_END: begin
          rec.st <= mrr_pkg::SLOT_ALLOC;
          state  <= ret;
        end
        S_FIN: begin
          ret       <= S_IDLE;
          done_pend <= 1'b1;
          state     <= S_CUR;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `ASSERT_IMP(a_jump_means_done, out_valid && do_jump, status == mrr_pkg::STAT_DONE)
  `ASSERT_IMP(a_active_level_nonempty, state == S_IDLE && !act_none && !recheck, cnt[act] != '0)

endmodule

/* hdl/mrr_ram.sv */
// Simple dual-port RAM: one write port, one registered read port.
module mrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
